/* sv/wss_pkg.sv */
`timescale 1ns / 1ps

package wss_pkg;

    localparam int PIX_W     = 8;
    localparam int LUMP_W    = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int SCORE_W   = 18;
    localparam int MEAN_W    = 17;
    localparam int FRAC_BITS = 16;

    localparam logic [MEAN_W-1:0]    Q16_ONE   = 17'h10000;
    localparam logic [16:0]          RECIP_255 = 17'd65793;
    localparam logic [CFG_IDX_W-1:0] REG_C1    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_C2    = 1'b1;
    localparam logic [CFG_W-1:0]     C1_RESET  = 20'd26634;
    localparam logic [CFG_W-1:0]     C2_RESET  = 20'd239708;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LUMP,
        S_CORR,
        S_MUL,
        S_ACC,
        S_FIN,
        S_LSTART,
        S_LWAIT,
        S_CSTART,
        S_CWAIT,
        S_PROD,
        S_UPD,
        S_MSTART,
        S_MWAIT,
        S_OUT
    } state_t;

    // Steps of the shared multiplier
    typedef enum logic [3:0] {
        OP_SQA,
        OP_SQB,
        OP_CRS,
        OP_NN,
        OP_C1,
        OP_C2,
        OP_SASB,
        OP_SASA,
        OP_SBSB,
        OP_QA_LO,
        OP_QA_HI,
        OP_QB_LO,
        OP_QB_HI,
        OP_P_LO,
        OP_P_HI
    } op_t;

    function automatic op_t op_after(input op_t op);
        op_t nxt;
        case (op)
            OP_SQA:   nxt = OP_SQB;
            OP_SQB:   nxt = OP_CRS;
            OP_CRS:   nxt = OP_NN;
            OP_NN:    nxt = OP_C1;
            OP_C1:    nxt = OP_C2;
            OP_C2:    nxt = OP_SASB;
            OP_SASB:  nxt = OP_SASA;
            OP_SASA:  nxt = OP_SBSB;
            OP_SBSB:  nxt = OP_QA_LO;
            OP_QA_LO: nxt = OP_QA_HI;
            OP_QA_HI: nxt = OP_QB_LO;
            OP_QB_LO: nxt = OP_QB_HI;
            OP_QB_HI: nxt = OP_P_LO;
            OP_P_LO:  nxt = OP_P_HI;
            default:  nxt = OP_SQA;
        endcase
        return nxt;
    endfunction

endpackage

/* sv/wss_if.sv */
`timescale 1ns / 1ps

interface wss_pix_if
    import wss_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red_a;
    logic [PIX_W-1:0]  green_a;
    logic [PIX_W-1:0]  blue_a;
    logic [PIX_W-1:0]  alpha_a;
    logic [PIX_W-1:0]  red_b;
    logic [PIX_W-1:0]  green_b;
    logic [PIX_W-1:0]  blue_b;
    logic [PIX_W-1:0]  alpha_b;
    logic              window_end;
    logic              image_end;

    modport source (
        output valid, red_a, green_a, blue_a, alpha_a,
        output red_b, green_b, blue_b, alpha_b, window_end, image_end,
        input  ready
    );
    modport sink (
        input  valid, red_a, green_a, blue_a, alpha_a,
        input  red_b, green_b, blue_b, alpha_b, window_end, image_end,
        output ready
    );
endinterface

interface wss_res_if
    import wss_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] window_ssim;
    logic [MEAN_W-1:0]         image_ssim;
    logic                      image_done;

    modport source (output valid, window_ssim, image_ssim, image_done, input ready);
    modport sink   (input  valid, window_ssim, image_ssim, image_done, output ready);
endinterface

interface wss_cfg_if
    import wss_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

/* sv/wss_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module wss_div
    import wss_pkg::*;
#(
    parameter int W      = 51,
    parameter int STEP_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      rem_init,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      dvd_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      den_reg;
    logic [W-1:0]      shifted;
    logic              ge;

    // Shift in next dividend bit and trial-subtract
    assign shifted = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign ge      = (shifted >= den_reg);

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - den_reg) : shifted;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/windowed_ssim_engine.sv */
`timescale 1ns / 1ps

// Channel  Dir   Handshake      Payload
// pix      in    valid/ready    RGBA pair, window_end, image_end
// res      out   valid/ready    window_ssim, image_ssim, image_done
// cfg      in    valid/ready    index, data (stabilizers C1, C2)
//
// A pixel that does not close a window passes through capture, a lump step,
// a correction step and three multiply/accumulate steps. A closing pixel
// adds 12 shared-multiplier steps, up to two fractional divisions and, at
// image end, a mean division if needed; the result then waits in its
// register until taken.
// Reset (rst_n, asynchronous) clears sums, counts and loads the default
// stabilizers. pix.ready is low while an item is in work or a result waits.
module windowed_ssim_engine
    import wss_pkg::*;
#(
    parameter int WINDOW_SIDE       = 8,
    parameter int WINDOW_COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    wss_pix_if.sink    pix,
    wss_res_if.source  res,
    wss_cfg_if.sink    cfg
);

    localparam int PIX_MAX = WINDOW_SIDE * WINDOW_SIDE;
    localparam int CNT_W   = $clog2(PIX_MAX + 1);
    localparam int SUM_W   = LUMP_W + CNT_W;
    localparam int SQ_W    = 2 * LUMP_W + CNT_W;
    localparam int NN_W    = 2 * CNT_W;
    localparam int MUL_W   = (SUM_W > CFG_W) ? SUM_W : CFG_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 2 * SUM_W + 4;
    localparam int SEEN_W  = WINDOW_COUNT_BITS + 1;
    localparam int TOT_W   = WINDOW_COUNT_BITS + 18;
    localparam int DIV_W   = (ACC_W + 1 > TOT_W) ? ACC_W + 1 : TOT_W;
    localparam int STEP_W  = $clog2(DIV_W + 1);
    localparam int X_W     = 24;

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [CFG_W-1:0]  c1_reg, c2_reg;
    logic [SUM_W-1:0]  sa_reg, sb_reg;
    logic [SQ_W-1:0]   qa_reg, qb_reg, p_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic [SEEN_W-1:0] seen_reg;

    logic [X_W-1:0]    xa_reg, xb_reg;
    logic [LUMP_W-1:0] ra_reg, rb_reg;
    logic [LUMP_W-1:0] la_reg, lb_reg;
    logic              wend_reg, iend_reg;
    logic [NN_W-1:0]   nn_reg;
    logic [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0] ln_reg, ld_reg, cn_reg, cd_reg, va_reg, vb_reg;
    logic [MEAN_W-1:0] lum_reg, con_reg, mean_reg;
    logic              neg_reg;
    logic signed [SCORE_W-1:0] score_reg;

    logic              pix_fire, res_fire, cfg_fire;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0] p_acc, p_hi, ln_pos, cn_mag, va_pos, vb_pos;
    logic              lum_one, con_one, cn_neg, close_win, mean_need;
    logic [LUMP_W-1:0] lump_a, lump_b;
    logic [X_W+16:0]   recip_a, recip_b;
    logic [33:0]       lc_prod;
    logic [MEAN_W-1:0] lc_mag;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_rem, div_dvd, div_den, div_quo;
    logic [STEP_W-1:0] div_steps;

    assign pix_fire = pix.valid && pix.ready;
    assign res_fire = res.valid && res.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    // Lump: floor(x*64/255) by reciprocal multiply and one correction
    assign recip_a = xa_reg * RECIP_255;
    assign recip_b = xb_reg * RECIP_255;
    assign lump_a = ra_reg + LUMP_W'(((xa_reg - ({8'd0, ra_reg, 8'd0} - X_W'(ra_reg)))
                    >= X_W'(255)) ? 1 : 0);
    assign lump_b = rb_reg + LUMP_W'(((xb_reg - ({8'd0, rb_reg, 8'd0} - X_W'(rb_reg)))
                    >= X_W'(255)) ? 1 : 0);

    // Shared product viewed as an accumulator term
    assign p_acc = $signed({{(ACC_W-PROD_W){1'b0}}, mul_reg});
    assign p_hi  = p_acc <<< SUM_W;

    // Factor checks ahead of division
    assign ln_pos  = (ln_reg < 0) ? '0 : ln_reg;
    assign lum_one = (ld_reg <= 0) || (ln_pos >= ld_reg);
    assign cn_neg  = (cn_reg < 0);
    assign cn_mag  = cn_neg ? -cn_reg : cn_reg;
    assign con_one = (cd_reg <= 0) || (cn_mag >= cd_reg);
    assign va_pos  = (va_reg < 0) ? '0 : va_reg;
    assign vb_pos  = (vb_reg < 0) ? '0 : vb_reg;

    assign close_win = wend_reg || iend_reg || (cnt_reg == CNT_W'(PIX_MAX));
    assign mean_need = (tot_reg > 0) && (seen_reg != '0);

    assign lc_prod = lum_reg * con_reg;
    assign lc_mag  = lc_prod[FRAC_BITS+MEAN_W-1:FRAC_BITS];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (pix_fire) state_next = S_LUMP;
            S_LUMP:   state_next = S_CORR;
            S_CORR:   state_next = S_MUL;
            S_MUL:    state_next = S_ACC;
            S_ACC:
            begin
                if (op_reg == OP_CRS)
                    state_next = close_win ? S_MUL : S_IDLE;
                else if (op_reg == OP_P_HI)
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            end
            S_FIN:    state_next = S_LSTART;
            S_LSTART: state_next = lum_one ? S_CSTART : S_LWAIT;
            S_LWAIT:  if (div_done) state_next = S_CSTART;
            S_CSTART: state_next = con_one ? S_PROD : S_CWAIT;
            S_CWAIT:  if (div_done) state_next = S_PROD;
            S_PROD:   state_next = S_UPD;
            S_UPD:    state_next = iend_reg ? S_MSTART : S_OUT;
            S_MSTART: state_next = mean_need ? S_MWAIT : S_OUT;
            S_MWAIT:  if (div_done) state_next = S_OUT;
            S_OUT:    if (res_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs: handshakes, multiplier operands, divider request
    always_comb
    begin
        pix.ready = (state_reg == S_IDLE);
        res.valid = (state_reg == S_OUT);
        case (op_reg)
            OP_SQA:   begin mul_a = MUL_W'(la_reg);  mul_b = MUL_W'(la_reg); end
            OP_SQB:   begin mul_a = MUL_W'(lb_reg);  mul_b = MUL_W'(lb_reg); end
            OP_CRS:   begin mul_a = MUL_W'(la_reg);  mul_b = MUL_W'(lb_reg); end
            OP_NN:    begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(cnt_reg); end
            OP_C1:    begin mul_a = MUL_W'(c1_reg);  mul_b = MUL_W'(nn_reg); end
            OP_C2:    begin mul_a = MUL_W'(c2_reg);  mul_b = MUL_W'(nn_reg); end
            OP_SASB:  begin mul_a = MUL_W'(sa_reg);  mul_b = MUL_W'(sb_reg); end
            OP_SASA:  begin mul_a = MUL_W'(sa_reg);  mul_b = MUL_W'(sa_reg); end
            OP_SBSB:  begin mul_a = MUL_W'(sb_reg);  mul_b = MUL_W'(sb_reg); end
            OP_QA_LO: begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(qa_reg[SUM_W-1:0]); end
            OP_QA_HI: begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(qa_reg[SQ_W-1:SUM_W]); end
            OP_QB_LO: begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(qb_reg[SUM_W-1:0]); end
            OP_QB_HI: begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(qb_reg[SQ_W-1:SUM_W]); end
            OP_P_LO:  begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(p_reg[SUM_W-1:0]); end
            OP_P_HI:  begin mul_a = MUL_W'(cnt_reg); mul_b = MUL_W'(p_reg[SQ_W-1:SUM_W]); end
            default:  begin mul_a = '0;              mul_b = '0; end
        endcase
        div_start = 1'b0;
        div_rem   = DIV_W'($unsigned(ln_pos));
        div_dvd   = '0;
        div_den   = DIV_W'($unsigned(ld_reg));
        div_steps = STEP_W'(FRAC_BITS);
        case (state_reg)
            S_LSTART: div_start = !lum_one;
            S_CSTART:
            begin
                div_start = !con_one;
                div_rem   = DIV_W'($unsigned(cn_mag));
                div_den   = DIV_W'($unsigned(cd_reg));
            end
            S_MSTART:
            begin
                div_start = mean_need;
                div_rem   = '0;
                div_dvd   = DIV_W'($unsigned(tot_reg)) << (DIV_W - TOT_W);
                div_den   = DIV_W'(seen_reg);
                div_steps = STEP_W'(TOT_W);
            end
            default:  div_start = 1'b0;
        endcase
    end

    // Hold state and advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SQA;
            c1_reg    <= C1_RESET;
            c2_reg    <= C2_RESET;
            sa_reg    <= '0;
            sb_reg    <= '0;
            qa_reg    <= '0;
            qb_reg    <= '0;
            p_reg     <= '0;
            cnt_reg   <= '0;
            tot_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                case (cfg.index)
                    REG_C1:  c1_reg <= cfg.data;
                    REG_C2:  c2_reg <= cfg.data;
                    default: c1_reg <= c1_reg;
                endcase
            end
            case (state_reg)
                S_CORR:
                begin
                    sa_reg  <= sa_reg + SUM_W'(lump_a);
                    sb_reg  <= sb_reg + SUM_W'(lump_b);
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    op_reg  <= OP_SQA;
                end
                S_ACC:
                begin
                    op_reg <= op_after(op_reg);
                    case (op_reg)
                        OP_SQA:  qa_reg <= qa_reg + mul_reg[SQ_W-1:0];
                        OP_SQB:  qb_reg <= qb_reg + mul_reg[SQ_W-1:0];
                        OP_CRS:  p_reg  <= p_reg + mul_reg[SQ_W-1:0];
                        default: qa_reg <= qa_reg;
                    endcase
                end
                S_UPD:
                begin
                    sa_reg  <= '0;
                    sb_reg  <= '0;
                    qa_reg  <= '0;
                    qb_reg  <= '0;
                    p_reg   <= '0;
                    cnt_reg <= '0;
                    if (!seen_reg[WINDOW_COUNT_BITS])
                    begin
                        tot_reg  <= tot_reg + TOT_W'(score_reg);
                        seen_reg <= seen_reg + SEEN_W'(1);
                    end
                end
                S_MSTART:
                begin
                    if (!mean_need)
                    begin
                        tot_reg  <= '0;
                        seen_reg <= '0;
                    end
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        tot_reg  <= '0;
                        seen_reg <= '0;
                    end
                end
                default: op_reg <= op_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pix_fire)
                begin
                    xa_reg <= {(X_W-6)'((10'(pix.red_a) + 10'(pix.green_a) + 10'(pix.blue_a))
                               * 10'(pix.alpha_a)), 6'd0};
                    xb_reg <= {(X_W-6)'((10'(pix.red_b) + 10'(pix.green_b) + 10'(pix.blue_b))
                               * 10'(pix.alpha_b)), 6'd0};
                    wend_reg <= pix.window_end;
                    iend_reg <= pix.image_end;
                end
            end
            S_LUMP:
            begin
                ra_reg <= recip_a[X_W+LUMP_W-1:X_W];
                rb_reg <= recip_b[X_W+LUMP_W-1:X_W];
            end
            S_CORR:
            begin
                la_reg <= lump_a;
                lb_reg <= lump_b;
            end
            S_MUL:    mul_reg <= mul_a * mul_b;
            S_ACC:
            begin
                case (op_reg)
                    OP_NN:    nn_reg <= mul_reg[NN_W-1:0];
                    OP_C1:
                    begin
                        ln_reg <= p_acc;
                        ld_reg <= p_acc;
                    end
                    OP_C2:
                    begin
                        cn_reg <= p_acc;
                        cd_reg <= p_acc;
                    end
                    OP_SASB:
                    begin
                        ln_reg <= ln_reg + (p_acc <<< 1);
                        cn_reg <= cn_reg - (p_acc <<< 1);
                    end
                    OP_SASA:
                    begin
                        ld_reg <= ld_reg + p_acc;
                        va_reg <= -p_acc;
                    end
                    OP_SBSB:
                    begin
                        ld_reg <= ld_reg + p_acc;
                        vb_reg <= -p_acc;
                    end
                    OP_QA_LO: va_reg <= va_reg + p_acc;
                    OP_QA_HI: va_reg <= va_reg + p_hi;
                    OP_QB_LO: vb_reg <= vb_reg + p_acc;
                    OP_QB_HI: vb_reg <= vb_reg + p_hi;
                    OP_P_LO:  cn_reg <= cn_reg + (p_acc <<< 1);
                    OP_P_HI:  cn_reg <= cn_reg + (p_hi <<< 1);
                    default:  nn_reg <= nn_reg;
                endcase
            end
            S_FIN:    cd_reg <= cd_reg + va_pos + vb_pos;
            S_LSTART: if (lum_one) lum_reg <= Q16_ONE;
            S_LWAIT:  if (div_done) lum_reg <= {1'b0, div_quo[FRAC_BITS-1:0]};
            S_CSTART:
            begin
                neg_reg <= (cd_reg > 0) && cn_neg;
                if (con_one)
                    con_reg <= Q16_ONE;
            end
            S_CWAIT:  if (div_done) con_reg <= {1'b0, div_quo[FRAC_BITS-1:0]};
            S_PROD:
            begin
                score_reg <= neg_reg ? -$signed({1'b0, lc_mag}) : $signed({1'b0, lc_mag});
            end
            S_UPD:    mean_reg <= '0;
            S_MWAIT:
            begin
                if (div_done)
                    mean_reg <= (div_quo > DIV_W'(Q16_ONE)) ? Q16_ONE : div_quo[MEAN_W-1:0];
            end
            default:  mul_reg <= mul_reg;
        endcase
    end

    wss_div #(
        .W      (DIV_W),
        .STEP_W (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign res.window_ssim = score_reg;
    assign res.image_ssim  = mean_reg;
    assign res.image_done  = iend_reg;

endmodule

/* sv/wss_check.sv */
`timescale 1ns / 1ps

module wss_check
    import wss_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pix_valid,
    input logic                      pix_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic signed [SCORE_W-1:0] window_ssim,
    input logic [MEAN_W-1:0]         image_ssim,
    input logic                      image_done
);

    // Busy after a pixel transfer
    a_busy_after_pix: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel taken while previous one in work");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(window_ssim) && $stable(image_done))
        else $error("stalled result changed");

    // Mean is zero unless the image closes
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !image_done |-> image_ssim == '0)
        else $error("image mean without image end");

    // Mean and window score within one
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> image_ssim <= Q16_ONE)
        else $error("image mean above one");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> window_ssim <= 18'sd65536 && window_ssim >= -18'sd65536)
        else $error("window score out of range");

endmodule

bind windowed_ssim_engine wss_check u_wss_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix.valid),
    .pix_ready   (pix.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .window_ssim (res.window_ssim),
    .image_ssim  (res.image_ssim),
    .image_done  (res.image_done)
);

/* tb/wss_checker.sv */
`timescale 1ns / 1ps

module wss_checker
    import wss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    wss_pix_if.sink pix_mon,
    wss_res_if.sink res_mon,
    wss_cfg_if.sink cfg_mon,
    output int      fail_count,
    output int      pending_count
);

    localparam int WIN_PIXELS = 64;
    localparam longint COUNT_LIMIT = 64'd1 << 16;

    typedef struct packed {
        logic signed [SCORE_W-1:0] window_ssim;
        logic [MEAN_W-1:0]         image_ssim;
        logic                      image_done;
    } score_t;

    score_t expected_scores[$];

    longint c1_val, c2_val;
    longint sum_a, sum_b, sq_a, sq_b, cross_ab, pix_n, total, win_cnt;

    // Reduce RGBA to a Q10.6 lump
    function automatic longint color_lump(input logic [7:0] r, g, b, a);
        longint s;
        s = longint'(r) + longint'(g) + longint'(b);
        return (s * longint'(a) * 64) / 255;
    endfunction

    // Q16 ratio by restoring division, saturating at 1.0
    function automatic longint ratio_q16(input longint num, input longint den);
        longint rem, q;
        rem = num;
        q = 0;
        if (den == 0 || num >= den)
            return 65536;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint window_similarity();
        longint nn, c1n, c2n, va, vb, cov, lnum, lden, cnum, cden, lum, con, mag;
        bit neg;
        nn = pix_n * pix_n;
        c1n = c1_val * nn;
        c2n = c2_val * nn;
        va = pix_n * sq_a - sum_a * sum_a;
        vb = pix_n * sq_b - sum_b * sum_b;
        cov = pix_n * cross_ab - sum_a * sum_b;
        lnum = 2 * sum_a * sum_b + c1n;
        lden = sum_a * sum_a + sum_b * sum_b + c1n;
        if (va < 0) va = 0;
        if (vb < 0) vb = 0;
        cnum = 2 * cov + c2n;
        cden = va + vb + c2n;
        lum = (lden <= 0) ? 65536 : ratio_q16(lnum < 0 ? 0 : lnum, lden);
        neg = 0;
        if (cden <= 0)
            con = 65536;
        else if (cnum < 0)
        begin
            neg = 1;
            con = ratio_q16(-cnum, cden);
        end
        else
            con = ratio_q16(cnum, cden);
        mag = (lum * con) >>> 16;
        return neg ? -mag : mag;
    endfunction

    assign pending_count = expected_scores.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint la, lb, sc, mean;
        score_t got, want;
        if (!rst_n)
        begin
            c1_val = C1_RESET;
            c2_val = C2_RESET;
            sum_a = 0; sum_b = 0; sq_a = 0; sq_b = 0; cross_ab = 0; pix_n = 0;
            total = 0; win_cnt = 0;
            fail_count <= 0;
            expected_scores.delete();
        end
        else
        begin
            // Track stabilizer writes
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_C1) c1_val = cfg_mon.data;
                else c2_val = cfg_mon.data;
            end
            // Accumulate each pixel transfer, predict on window close
            if (pix_mon.valid && pix_mon.ready)
            begin
                la = color_lump(pix_mon.red_a, pix_mon.green_a, pix_mon.blue_a, pix_mon.alpha_a);
                lb = color_lump(pix_mon.red_b, pix_mon.green_b, pix_mon.blue_b, pix_mon.alpha_b);
                sum_a += la; sum_b += lb;
                sq_a += la * la; sq_b += lb * lb; cross_ab += la * lb;
                pix_n++;
                if (pix_mon.window_end || pix_mon.image_end || pix_n >= WIN_PIXELS)
                begin
                    sc = window_similarity();
                    sum_a = 0; sum_b = 0; sq_a = 0; sq_b = 0; cross_ab = 0; pix_n = 0;
                    if (win_cnt < COUNT_LIMIT)
                    begin
                        total += sc;
                        win_cnt++;
                    end
                    mean = 0;
                    if (pix_mon.image_end)
                    begin
                        if (total > 0 && win_cnt > 0)
                        begin
                            mean = total / win_cnt;
                            if (mean > 65536) mean = 65536;
                        end
                        total = 0;
                        win_cnt = 0;
                    end
                    want.window_ssim = sc[SCORE_W-1:0];
                    want.image_ssim = mean[MEAN_W-1:0];
                    want.image_done = pix_mon.image_end;
                    expected_scores.push_back(want);
                end
            end
            // Compare each result transfer
            if (res_mon.valid && res_mon.ready)
            begin
                got.window_ssim = res_mon.window_ssim;
                got.image_ssim = res_mon.image_ssim;
                got.image_done = res_mon.image_done;
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result ssim=%0d mean=%0d done=%0b", $time,
                             got.window_ssim, got.image_ssim, got.image_done);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: expected ssim=%0d mean=%0d done=%0b, got ssim=%0d mean=%0d done=%0b",
                                 $time, want.window_ssim, want.image_ssim, want.image_done,
                                 got.window_ssim, got.image_ssim, got.image_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_windowed_ssim_engine.sv */
`timescale 1ns / 1ps

module tb_windowed_ssim_engine;
    import wss_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending_count;
    int   idle_cycles = 0;
    bit   quiet_phase;
    bit   hold_off;
    int   pix_sent;

    wss_pix_if pix ();
    wss_res_if res ();
    wss_cfg_if cfg ();

    windowed_ssim_engine dut (.clk(clk), .rst_n(rst_n), .pix(pix), .res(res), .cfg(cfg));

    wss_checker chk (
        .clk(clk), .rst_n(rst_n), .pix_mon(pix), .res_mon(res), .cfg_mon(cfg),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always #2 clk = ~clk;

    initial
    begin
        pix.valid = 0; pix.red_a = 0; pix.green_a = 0; pix.blue_a = 0; pix.alpha_a = 0;
        pix.red_b = 0; pix.green_b = 0; pix.blue_b = 0; pix.alpha_b = 0;
        pix.window_end = 0; pix.image_end = 0;
        cfg.valid = 0; cfg.index = REG_C1; cfg.data = 0;
        res.ready = 0;
    end

    // Result side: random stalls, a quiet stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_off)
            res.ready <= 1'b0;
        else
            res.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
            || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [63:0] rgba, input bit wend, input bit iend);
        @(posedge clk);
        if (!quiet_phase)
            while ($urandom_range(99) < 12) @(posedge clk);
        pix.valid <= 1'b1;
        {pix.red_a, pix.green_a, pix.blue_a, pix.alpha_a,
         pix.red_b, pix.green_b, pix.blue_b, pix.alpha_b} <= rgba;
        pix.window_end <= wend;
        pix.image_end <= iend;
        do @(posedge clk); while (!pix.ready);
        pix.valid <= 1'b0;
        pix_sent++;
    endtask

    function automatic logic [63:0] random_rgba(input int style);
        logic [31:0] a, b;
        a = $urandom;
        case (style)
            0: b = a;
            1: b = a ^ (32'h0101_0100 & $urandom);
            default: b = $urandom;
        endcase
        if ($urandom_range(9) == 0) a[7:0] = 8'hFF;
        return {a, b};
    endfunction

    // Random image: windows of random length, occasionally overlong
    task automatic send_image(input int windows, input int max_len);
        int len, style;
        for (int w = 0; w < windows; w++)
        begin
            len = $urandom_range(max_len, 1);
            style = $urandom_range(2);
            for (int p = 0; p < len; p++)
                send_pixel(random_rgba(style), p == len - 1 && len < 70 && $urandom_range(7) != 0,
                           w == windows - 1 && p == len - 1);
        end
    endtask

    task automatic settle();
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        quiet_phase = 0;
        hold_off = 0;
        pix_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, identical, inverted, alpha zero, single pixel windows
        send_pixel({32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, 0);
        send_pixel({32'h0000_0000, 32'h0000_0000}, 1, 0);
        send_pixel({32'hFFFF_FFFF, 32'h0000_0000}, 0, 0);
        send_pixel({32'h0000_0000, 32'hFFFF_FFFF}, 1, 0);
        send_pixel({32'hFFFF_FF00, 32'hFFFF_FFFF}, 0, 0);
        send_pixel({32'h0000_00FF, 32'h8080_80FF}, 0, 0);
        send_pixel({32'hFF00_00FF, 32'h00FF_00FF}, 1, 0);
        send_pixel({32'h1020_30FF, 32'hF0E0_D0FF}, 0, 0);
        send_pixel({32'hF0E0_D0FF, 32'h1020_30FF}, 0, 1);
        for (int i = 0; i < 66; i++)
            send_pixel({8'(i * 3), 8'(i), 8'(255 - i), 8'hFF, 8'(255 - i * 3), 8'(i), 8'(i), 8'hFF},
                       0, i == 65);
        settle();

        // Stabilizers at the extremes: zero denominators and saturation
        write_reg(REG_C1, 20'd0);
        write_reg(REG_C2, 20'd0);
        send_pixel({32'h0, 32'h0}, 1, 0);
        send_pixel({32'hFFFF_FFFF, 32'h0}, 0, 0);
        send_pixel({32'h0, 32'hFFFF_FFFF}, 0, 1);
        send_image(4, 10);
        settle();
        write_reg(REG_C1, 20'hFFFFF);
        write_reg(REG_C2, 20'hFFFFF);
        send_image(6, 20);
        settle();

        // Random images with the default settings, without random stalls
        quiet_phase = 1;
        write_reg(REG_C1, C1_RESET);
        write_reg(REG_C2, C2_RESET);
        send_image(12, 30);
        quiet_phase = 0;

        // Hold results off long enough to stall the pixel input
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            send_image(10, 3);
        join
        settle();

        while (pix_sent < 1950)
        begin
            if ($urandom_range(3) == 0)
            begin
                write_reg(REG_C1, CFG_W'($urandom_range(20'hFFFFF)));
                write_reg(REG_C2, CFG_W'($urandom_range(20'hFFFFF)));
            end
            send_image($urandom_range(8, 1), 70);
            settle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
